/* src/radix_base_converter_macros.svh */
// ----------------------------------------------------------------------------
// radix_base_converter assertion macros
// Concurrent assertion wrappers; empty bodies when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RADIX_BASE_CONVERTER_MACROS_SVH
`define RADIX_BASE_CONVERTER_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define RBC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen outside reset
`define RBC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RBC_ASSERT(lbl, clk, rst_n, prop, msg)
`define RBC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

/* src/rbc_pkg.sv */
// ----------------------------------------------------------------------------
// rbc_pkg
// Constants, types and character helpers of the radix base converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rbc_pkg;

  // field and register widths
  localparam int unsigned BASE_W = 6;
  localparam int unsigned CHAR_W = 8;

  // most digits one numeral can produce
  localparam int unsigned MAX_OUT = 32;

  // legal radix range
  localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;

  // register reset values
  localparam logic [BASE_W-1:0] SOURCE_BASE_RST = 6'd16;
  localparam logic [BASE_W-1:0] TARGET_BASE_RST = 6'd2;

  // register indexes
  localparam logic REG_SOURCE_BASE = 1'b0;
  localparam logic REG_TARGET_BASE = 1'b1;

  // ascii anchors
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_NINE = 8'd57;
  localparam logic [CHAR_W-1:0] ASCII_A    = 8'd65;
  localparam logic [CHAR_W-1:0] ASCII_Z    = 8'd90;
  localparam logic [CHAR_W-1:0] DEC_DIGITS = 8'd10;

  // decoded input character
  typedef struct packed {
    logic [BASE_W-1:0] value;
    logic              bad;
  } digit_t;

  // saturate a base register into the legal range
  function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
    if (b < BASE_MIN) begin
      return BASE_MIN;
    end else if (b > BASE_MAX) begin
      return BASE_MAX;
    end
    return b;
  endfunction

  // ascii character to digit value, anything else counts as zero
  function automatic digit_t char_value(input logic [CHAR_W-1:0] c);
    digit_t            res;
    logic [CHAR_W-1:0] diff;
    res  = '0;
    diff = '0;
    if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
      diff      = c - ASCII_ZERO;
      res.value = diff[BASE_W-1:0];
    end else if (c >= ASCII_A && c <= ASCII_Z) begin
      diff      = c - ASCII_A + DEC_DIGITS;
      res.value = diff[BASE_W-1:0];
    end else begin
      res.bad = 1'b1;
    end
    return res;
  endfunction

  // digit value to ascii character
  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [BASE_W-1:0] d);
    logic [CHAR_W-1:0] wide;
    wide = CHAR_W'(d);
    if (wide >= DEC_DIGITS) begin
      return wide - DEC_DIGITS + ASCII_A;
    end
    return wide + ASCII_ZERO;
  endfunction

endpackage

/* src/radix_base_converter.sv */
// ----------------------------------------------------------------------------
// radix_base_converter
// Converts an ascii numeral from one radix to another, one character per item.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid_i / in_ready_o) carries one character per item,
//   most significant first, with last_char_i on the final one. Each character
//   is a single multiply-accumulate into the value register.
//   On the last character the value is converted by a shared one-bit restoring
//   divider, remainders pushed on a stack memory, one per result digit. The
//   stack is then drained one digit at a time (registered memory read, then
//   output register); in_ready_o is low from the last character until the
//   final digit is loaded into the output register.
//   Output channel (out_valid_o / out_ready_i) carries one digit per item,
//   most significant first, last_digit_o on the final one, bad_input_o set on
//   every digit of a numeral that held a character outside 0-9 and A-Z.
//   A stalled receiver holds the output register and pauses the drain; the
//   next numeral may start while the final digit still waits.
//   Config writes (cfg_valid_i, always ready) set the two base registers.
//   Reset restores bases 16 and 2 and clears value, count and flags; the stack
//   needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "radix_base_converter_macros.svh"

module radix_base_converter #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // config write channel
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_index_i,
  input  logic [rbc_pkg::BASE_W-1:0] cfg_data_i,
  // input characters
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [rbc_pkg::CHAR_W-1:0] digit_char_i,
  input  logic                       last_char_i,
  // output digits
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [rbc_pkg::CHAR_W-1:0] out_char_o,
  output logic                       last_digit_o,
  output logic                       bad_input_o
);

  localparam int unsigned BW        = rbc_pkg::BASE_W;
  localparam int unsigned MW        = VALUE_WIDTH + BW;
  localparam int unsigned DIGIT_CAP =
    (STACK_DEPTH < rbc_pkg::MAX_OUT) ? STACK_DEPTH : rbc_pkg::MAX_OUT;
  localparam int unsigned CNT_W     = $clog2(DIGIT_CAP + 1);
  localparam int unsigned ADDR_W    = $clog2(STACK_DEPTH);
  localparam int unsigned BIT_W     = $clog2(VALUE_WIDTH);

  localparam logic [CNT_W-1:0] CNT_CAP  = CNT_W'(DIGIT_CAP);
  localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(VALUE_WIDTH - 1);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_POP  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [BW-1:0]          src_base_q, src_base_d;
  logic [BW-1:0]          tgt_base_q, tgt_base_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [BW-1:0]          rem_q, rem_d;
  logic [BIT_W-1:0]       bit_cnt_q, bit_cnt_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic                   bad_q, bad_d;
  logic                   out_valid_q, out_valid_d;
  logic [rbc_pkg::CHAR_W-1:0] out_char_q, out_char_d;
  logic                   out_last_q, out_last_d;
  logic                   out_bad_q, out_bad_d;

  logic [BW-1:0]          stack_mem [STACK_DEPTH];
  logic [BW-1:0]          rd_data_q;

  rbc_pkg::digit_t        dig;
  logic [BW-1:0]          src_base;
  logic [BW-1:0]          tgt_base;
  logic [MW-1:0]          mac_full;
  logic [BW:0]            rem_shift;
  logic                   rem_ge;
  logic [BW:0]            rem_sub;
  logic [BW-1:0]          rem_step;
  logic [VALUE_WIDTH-1:0] val_step;
  logic                   in_fire;
  logic                   out_free;
  logic                   push_en;
  logic                   pop_en;
  logic [ADDR_W-1:0]      push_addr;
  logic [ADDR_W-1:0]      pop_addr;
  logic [CNT_W-1:0]       count_dec;

  // handshake outputs
  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = (state_q == ST_IDLE);
  assign in_fire      = in_valid_i && in_ready_o;
  assign out_free     = !out_valid_q || out_ready_i;
  assign out_valid_o  = out_valid_q;
  assign out_char_o   = out_char_q;
  assign last_digit_o = out_last_q;
  assign bad_input_o  = out_bad_q;

  // config register writes
  always_comb begin
    src_base_d = src_base_q;
    tgt_base_d = tgt_base_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rbc_pkg::REG_SOURCE_BASE: src_base_d = cfg_data_i;
        rbc_pkg::REG_TARGET_BASE: tgt_base_d = cfg_data_i;
      endcase
    end
  end

  // character decode and horner step
  assign dig      = rbc_pkg::char_value(digit_char_i);
  assign src_base = rbc_pkg::clamp_base(src_base_q);
  assign tgt_base = rbc_pkg::clamp_base(tgt_base_q);
  assign mac_full = (MW'(acc_q) * MW'(src_base)) + MW'(dig.value);

  // shared divider: one restoring step per cycle
  assign rem_shift = {rem_q, val_q[VALUE_WIDTH-1]};
  assign rem_ge    = (rem_shift >= {1'b0, tgt_base});
  assign rem_sub   = rem_ge ? (rem_shift - {1'b0, tgt_base}) : rem_shift;
  assign rem_step  = rem_sub[BW-1:0];
  assign val_step  = {val_q[VALUE_WIDTH-2:0], rem_ge};

  // stack addressing
  assign count_dec = count_q - 1'b1;
  assign push_addr = count_q[ADDR_W-1:0];
  assign pop_addr  = count_dec[ADDR_W-1:0];
  assign push_en   = (state_q == ST_DIV) && (bit_cnt_q == BIT_LAST) && (count_q < CNT_CAP);
  assign pop_en    = (state_q == ST_POP);

  // sequencer
  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    val_d       = val_q;
    rem_d       = rem_q;
    bit_cnt_d   = bit_cnt_q;
    count_d     = count_q;
    bad_d       = bad_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_bad_d   = out_bad_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          bad_d = bad_q | dig.bad;
          if (last_char_i) begin
            val_d     = mac_full[VALUE_WIDTH-1:0];
            acc_d     = '0;
            rem_d     = '0;
            bit_cnt_d = '0;
            count_d   = '0;
            state_d   = ST_DIV;
          end else begin
            acc_d = mac_full[VALUE_WIDTH-1:0];
          end
        end
      end
      ST_DIV: begin
        val_d = val_step;
        if (bit_cnt_q == BIT_LAST) begin
          rem_d     = '0;
          bit_cnt_d = '0;
          if (push_en) begin
            count_d = count_q + 1'b1;
          end
          if (val_step == '0) begin
            state_d = ST_POP;
          end
        end else begin
          rem_d     = rem_step;
          bit_cnt_d = bit_cnt_q + 1'b1;
        end
      end
      ST_POP: begin
        count_d = count_dec;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = rbc_pkg::digit_ascii(rd_data_q);
          out_last_d  = (count_q == '0);
          out_bad_d   = bad_q;
          if (count_q == '0) begin
            bad_d   = 1'b0;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_POP;
          end
        end
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      src_base_q  <= rbc_pkg::SOURCE_BASE_RST;
      tgt_base_q  <= rbc_pkg::TARGET_BASE_RST;
      acc_q       <= '0;
      bit_cnt_q   <= '0;
      count_q     <= '0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      src_base_q  <= src_base_d;
      tgt_base_q  <= tgt_base_d;
      acc_q       <= acc_d;
      bit_cnt_q   <= bit_cnt_d;
      count_q     <= count_d;
      bad_q       <= bad_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    rem_q      <= rem_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    out_bad_q  <= out_bad_d;
  end

  // remainder stack write
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      stack_mem[push_addr] <= rem_step;
    end
  end

  // remainder stack registered read
  always_ff @(posedge clk_i) begin
    if (pop_en) begin
      rd_data_q <= stack_mem[pop_addr];
    end
  end

  // checks
  `RBC_ASSERT_NEVER(a_count_cap, clk_i, rst_ni, count_q > CNT_CAP, "stack count beyond cap")
  `RBC_ASSERT(a_last_blocks, clk_i, rst_ni, in_fire && last_char_i |=> !in_ready_o, "input taken during conversion")
  `RBC_ASSERT(a_bit_cnt_idle, clk_i, rst_ni, state_q != ST_DIV |-> bit_cnt_q == '0, "divider step count left over")
  `RBC_ASSERT(a_pop_nonempty, clk_i, rst_ni, state_q == ST_POP |-> count_q != '0, "pop from empty stack")

endmodule

/* sim/radix_base_converter_test.sv */
// ----------------------------------------------------------------------------
// radix_base_converter_test
// Self-checking bench for the radix base converter. A short table of numerals
// covers the extremes, the bad characters and the saturated bases. Random
// numerals follow under random bases. Every digit that comes out is checked
// against a table value or a predictor of the accumulate-and-divide conversion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module radix_base_converter_test;

  localparam int unsigned CHAR_W        = rbc_pkg::CHAR_W;
  localparam int unsigned BASE_W        = rbc_pkg::BASE_W;
  localparam int unsigned CLK_HALF      = 6;
  localparam int unsigned RESET_CYCLES  = 7;
  localparam int unsigned RANDOM_ITEMS  = 400;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned END_CYCLES    = 40;
  // worst quiet stretch: the division of a 32-digit result, plus long stalls
  localparam int unsigned STALL_LIMIT   = 8000;

  typedef enum logic [1:0] {
    ROW_CHAR,
    ROW_CFG
  } row_kind_e;

  // one row of the directed table; known_n of zero means use the predictor
  typedef struct packed {
    row_kind_e         kind;
    logic [CHAR_W-1:0] chr;
    logic              last;
    logic              idx;
    logic [BASE_W-1:0] data;
    logic [BASE_W-1:0] known_n;
    logic [CHAR_W-1:0] known_chr;
    logic              known_bad;
  } stim_row_t;

  // one expected output digit
  typedef struct packed {
    logic [CHAR_W-1:0] glyph;
    logic              tail;
    logic              bad;
  } digit_item_t;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              cfg_valid_i  = 1'b0;
  logic              cfg_ready_o;
  logic              cfg_index_i  = rbc_pkg::REG_SOURCE_BASE;
  logic [BASE_W-1:0] cfg_data_i   = '0;
  logic              in_valid_i   = 1'b0;
  logic              in_ready_o;
  logic [CHAR_W-1:0] digit_char_i = '0;
  logic              last_char_i  = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i  = 1'b0;
  logic [CHAR_W-1:0] out_char_o;
  logic              last_digit_o;
  logic              bad_input_o;

  // predictor state
  logic [31:0]       acc_value = '0;
  logic              bad_flag  = 1'b0;
  logic [BASE_W-1:0] src_radix = rbc_pkg::SOURCE_BASE_RST;
  logic [BASE_W-1:0] dst_radix = rbc_pkg::TARGET_BASE_RST;

  digit_item_t       pending_digits[$];
  stim_row_t         stim_rows[$];
  digit_item_t       head_digit;
  int unsigned       mismatches   = 0;
  int unsigned       random_items = 0;
  int unsigned       idle_cycles  = 0;
  int unsigned       sink_left    = 0;
  logic              sink_on      = 1'b0;
  logic              steady_phase = 1'b0;

  radix_base_converter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .digit_char_i(digit_char_i),
    .last_char_i (last_char_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .last_digit_o(last_digit_o),
    .bad_input_o (bad_input_o)
  );

  // clock
  always #(CLK_HALF) clk_i = ~clk_i;

  // gap length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(12, 60);
  endfunction

  // a base register as the block uses it, held inside the legal range
  function automatic logic [BASE_W-1:0] sat_radix(input logic [BASE_W-1:0] b);
    if (b < rbc_pkg::BASE_MIN) return rbc_pkg::BASE_MIN;
    if (b > rbc_pkg::BASE_MAX) return rbc_pkg::BASE_MAX;
    return b;
  endfunction

  // digit value to its numeral character
  function automatic logic [CHAR_W-1:0] glyph_of(input int unsigned d);
    if (d >= rbc_pkg::DEC_DIGITS) return CHAR_W'(d - rbc_pkg::DEC_DIGITS) + rbc_pkg::ASCII_A;
    return CHAR_W'(d) + rbc_pkg::ASCII_ZERO;
  endfunction

  // fold one accepted character into the value; on the last one, queue its digits
  function automatic void absorb_char(input logic [CHAR_W-1:0] chr, input logic last,
                                      input logic [BASE_W-1:0] known_n,
                                      input logic [CHAR_W-1:0] known_chr,
                                      input logic known_bad);
    logic [31:0]       dval;
    logic [31:0]       v;
    logic [31:0]       tb;
    logic [BASE_W-1:0] rems [rbc_pkg::MAX_OUT];
    int                n;
    digit_item_t       item;
    dval = '0;
    if (chr >= rbc_pkg::ASCII_ZERO && chr <= rbc_pkg::ASCII_NINE) begin
      dval = 32'(chr - rbc_pkg::ASCII_ZERO);
    end else if (chr >= rbc_pkg::ASCII_A && chr <= rbc_pkg::ASCII_Z) begin
      dval = 32'(chr - rbc_pkg::ASCII_A) + 32'(rbc_pkg::DEC_DIGITS);
    end else begin
      bad_flag = 1'b1;
    end
    acc_value = acc_value * 32'(sat_radix(src_radix)) + dval;
    if (!last) return;
    if (known_n != 0) begin
      for (int i = int'(known_n); i > 0; i--) begin
        item.glyph = known_chr;
        item.tail  = (i == 1);
        item.bad   = known_bad;
        pending_digits.push_back(item);
      end
    end else begin
      // remainders least significant first, then out most significant first
      tb = 32'(sat_radix(dst_radix));
      v  = acc_value;
      n  = 0;
      do begin
        if (n < rbc_pkg::MAX_OUT) begin
          rems[n] = BASE_W'(v % tb);
          n++;
        end
        v = v / tb;
      end while (v != 0);
      for (int i = n - 1; i >= 0; i--) begin
        item.glyph = glyph_of(32'(rems[i]));
        item.tail  = (i == 0);
        item.bad   = bad_flag;
        pending_digits.push_back(item);
      end
    end
    acc_value = '0;
    bad_flag  = 1'b0;
  endfunction

  function automatic stim_row_t char_row(input logic [CHAR_W-1:0] chr, input logic last,
                                         input logic [BASE_W-1:0] known_n,
                                         input logic [CHAR_W-1:0] known_chr,
                                         input logic known_bad);
    stim_row_t row;
    row           = '0;
    row.kind      = ROW_CHAR;
    row.chr       = chr;
    row.last      = last;
    row.known_n   = known_n;
    row.known_chr = known_chr;
    row.known_bad = known_bad;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input logic idx, input logic [BASE_W-1:0] data);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_CFG;
    row.idx  = idx;
    row.data = data;
    return row;
  endfunction

  task automatic report_mismatch(input string what, input logic [CHAR_W-1:0] got,
                                 input logic [CHAR_W-1:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // present one character item and wait until it is taken
  task automatic send_char(input logic [CHAR_W-1:0] chr, input logic last,
                           input logic [BASE_W-1:0] known_n,
                           input logic [CHAR_W-1:0] known_chr, input logic known_bad);
    int unsigned gap;
    gap = steady_phase ? 0 : pick_gap();
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    digit_char_i <= chr;
    last_char_i  <= last;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    absorb_char(chr, last, known_n, known_chr, known_bad);
  endtask

  // stop sending and wait for every queued digit, then a little more
  task automatic settle_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input logic [BASE_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    if (idx == rbc_pkg::REG_SOURCE_BASE) begin
      src_radix = data;
    end else begin
      dst_radix = data;
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // base setting for a random phase, extremes and out-of-range values included
  function automatic logic [BASE_W-1:0] pick_radix();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return rbc_pkg::BASE_MIN;
    if (roll == 1) return rbc_pkg::BASE_MAX;
    if (roll == 2) return BASE_W'($urandom_range(0, 63));
    return BASE_W'($urandom_range(2, 36));
  endfunction

  // one random numeral: mostly legal digits of the source base, some noise
  task automatic send_numeral();
    int unsigned       len;
    int unsigned       roll;
    int unsigned       radix;
    logic              noisy;
    logic [CHAR_W-1:0] chr;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      len = $urandom_range(1, 4);
    end else if (roll < 95) begin
      len = $urandom_range(5, 8);
    end else begin
      len = $urandom_range(9, 14);
    end
    noisy = ($urandom_range(0, 4) == 0);
    radix = 32'(sat_radix(src_radix));
    for (int k = 1; k <= int'(len); k++) begin
      if (!noisy) begin
        chr = glyph_of($urandom_range(0, radix - 1));
      end else if ($urandom_range(0, 1) == 1) begin
        chr = CHAR_W'($urandom_range(0, 255));
      end else begin
        chr = glyph_of($urandom_range(0, 35));
      end
      send_char(chr, k == int'(len), '0, '0, 1'b0);
      random_items++;
    end
  endtask

  // receiver: alternating ready and stall stretches
  always @(negedge clk_i) begin
    if (sink_left == 0) begin
      sink_on   = ~sink_on;
      sink_left = sink_on ? $urandom_range(1, 24) : pick_gap();
    end else begin
      sink_left--;
    end
    out_ready_i <= steady_phase | sink_on;
  end

  // check each accepted digit against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_digits.size() == 0) begin
        report_mismatch("unexpected digit", out_char_o, '0);
      end else begin
        head_digit = pending_digits.pop_front();
        if (out_char_o !== head_digit.glyph) begin
          report_mismatch("out_char", out_char_o, head_digit.glyph);
        end
        if (last_digit_o !== head_digit.tail) begin
          report_mismatch("last_digit", CHAR_W'(last_digit_o), CHAR_W'(head_digit.tail));
        end
        if (bad_input_o !== head_digit.bad) begin
          report_mismatch("bad_input", CHAR_W'(bad_input_o), CHAR_W'(head_digit.bad));
        end
      end
    end
  end

  // watchdog on cycles with no item moving on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // stimulus
  initial begin
    // reset bases: hex in, binary out
    stim_rows.push_back(char_row("0", 1'b1, 6'd1, "0", 1'b0));
    repeat (7) stim_rows.push_back(char_row("F", 1'b0, '0, '0, 1'b0));
    stim_rows.push_back(char_row("F", 1'b1, 6'd32, "1", 1'b0));
    // widest bases
    stim_rows.push_back(cfg_row(rbc_pkg::REG_SOURCE_BASE, rbc_pkg::BASE_MAX));
    stim_rows.push_back(cfg_row(rbc_pkg::REG_TARGET_BASE, rbc_pkg::BASE_MAX));
    stim_rows.push_back(char_row("Z", 1'b1, 6'd1, "Z", 1'b0));
    // registers outside the legal range act as 2 and 36
    stim_rows.push_back(cfg_row(rbc_pkg::REG_SOURCE_BASE, 6'd0));
    stim_rows.push_back(cfg_row(rbc_pkg::REG_TARGET_BASE, 6'd63));
    stim_rows.push_back(char_row("1", 1'b0, '0, '0, 1'b0));
    stim_rows.push_back(char_row("1", 1'b0, '0, '0, 1'b0));
    stim_rows.push_back(char_row("0", 1'b1, '0, '0, 1'b0));
    // decimal: bad characters count as zero and flag the numeral
    stim_rows.push_back(cfg_row(rbc_pkg::REG_SOURCE_BASE, 6'd10));
    stim_rows.push_back(cfg_row(rbc_pkg::REG_TARGET_BASE, 6'd10));
    stim_rows.push_back(char_row(8'h00, 1'b0, '0, '0, 1'b0));
    stim_rows.push_back(char_row("5", 1'b1, 6'd1, "5", 1'b1));
    stim_rows.push_back(char_row(8'hFF, 1'b1, 6'd1, "0", 1'b1));
    stim_rows.push_back(char_row("a", 1'b1, 6'd1, "0", 1'b1));
    stim_rows.push_back(char_row("/", 1'b0, '0, '0, 1'b0));
    stim_rows.push_back(char_row(":", 1'b0, '0, '0, 1'b0));
    stim_rows.push_back(char_row("@", 1'b0, '0, '0, 1'b0));
    stim_rows.push_back(char_row("[", 1'b0, '0, '0, 1'b0));
    stim_rows.push_back(char_row("7", 1'b1, 6'd1, "7", 1'b1));
    // digit above the source base goes through unchecked
    stim_rows.push_back(char_row("Z", 1'b0, '0, '0, 1'b0));
    stim_rows.push_back(char_row("9", 1'b1, '0, '0, 1'b0));
    // source base below the minimum
    stim_rows.push_back(cfg_row(rbc_pkg::REG_SOURCE_BASE, 6'd1));
    stim_rows.push_back(cfg_row(rbc_pkg::REG_TARGET_BASE, rbc_pkg::BASE_MIN));
    stim_rows.push_back(char_row("1", 1'b1, 6'd1, "1", 1'b0));

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (stim_rows[r]) begin
      if (stim_rows[r].kind == ROW_CFG) begin
        settle_idle();
        write_cfg(stim_rows[r].idx, stim_rows[r].data);
      end else begin
        send_char(stim_rows[r].chr, stim_rows[r].last, stim_rows[r].known_n,
                  stim_rows[r].known_chr, stim_rows[r].known_bad);
      end
    end

    // random phases, each under a fresh pair of bases
    while (random_items < RANDOM_ITEMS) begin
      settle_idle();
      write_cfg(rbc_pkg::REG_SOURCE_BASE, pick_radix());
      write_cfg(rbc_pkg::REG_TARGET_BASE, pick_radix());
      steady_phase = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 8)) begin
        send_numeral();
        // now and then hold off until the output side has drained
        if ($urandom_range(0, 5) == 0) begin
          settle_idle();
        end
      end
      steady_phase = 1'b0;
    end

    settle_idle();
    repeat (END_CYCLES) @(posedge clk_i);
    if (pending_digits.size() != 0) begin
      report_mismatch("digits left over", CHAR_W'(pending_digits.size()), '0);
    end
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
